@@ rtl/pen_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pen_pkg
// Shared types, constants and character helpers for the percent-encoding
// normaliser.
// ----------------------------------------------------------------------------
package pen_pkg;

    localparam logic [63:0] MASK_LOW_RESET  = 64'hAC00_9FD2_0000_0000;
    localparam logic [63:0] MASK_HIGH_RESET = 64'h0000_0000_0000_0001;

    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_USCR  = 8'h5F;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic CFG_MASK_LOW  = 1'b0;
    localparam logic CFG_MASK_HIGH = 1'b1;

    typedef enum logic [1:0] {
        OP_PASS  = 2'd0,
        OP_ESC   = 2'd1,
        OP_ERROR = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data;
        logic       last;
    } op_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_digit(b) || ((b >= 8'h61) && (b <= 8'h66)) ||
               ((b >= 8'h41) && (b <= 8'h46));
    endfunction

    function automatic logic is_plain(input logic [7:0] b);
        return is_letter(b) || is_digit(b) || (b == CHAR_DASH) ||
               (b == CHAR_DOT) || (b == CHAR_USCR) || (b == CHAR_TILDE);
    endfunction

    // uppercase hex character of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10)
        begin
            r = 8'h30 + {4'd0, n};
        end
        else
        begin
            r = 8'h37 + {4'd0, n};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/pen_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pen_front
// Classifies each input word against the escape state and allow masks and
// hands one operation per producing word to the queue.
// ----------------------------------------------------------------------------
module pen_front
    import pen_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  in_byte,
    input  wire logic        last_byte,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data,
    output logic             op_push,
    output op_t              op
);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        discard_reg, discard_next;
    logic [63:0] mask_low_reg, mask_high_reg;
    logic        allowed;
    logic        emit;

    always_comb
    begin
        if (in_byte[7])
        begin
            allowed = 1'b0;
        end
        else if (in_byte[6])
        begin
            allowed = mask_high_reg[in_byte[5:0]];
        end
        else
        begin
            allowed = mask_low_reg[in_byte[5:0]];
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        discard_next = discard_reg;
        emit         = 1'b0;
        op.kind      = OP_PASS;
        op.data      = in_byte;
        op.last      = last_byte;
        if (discard_reg)
        begin
            if (last_byte)
            begin
                discard_next = 1'b0;
            end
        end
        else
        begin
            emit = 1'b1;
            case (phase_reg)
                PH_FIRST, PH_SECOND:
                begin
                    if (!is_hex(in_byte) || ((phase_reg == PH_FIRST) && last_byte))
                    begin
                        op.kind      = OP_ERROR;
                        phase_next   = PH_IDLE;
                        discard_next = !last_byte;
                    end
                    else if (phase_reg == PH_FIRST)
                    begin
                        phase_next = PH_SECOND;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (in_byte == CHAR_PCT)
                    begin
                        if (last_byte)
                        begin
                            op.kind = OP_ERROR;
                        end
                        else
                        begin
                            phase_next = PH_FIRST;
                        end
                    end
                    else if (!(is_plain(in_byte) || allowed))
                    begin
                        op.kind = OP_ESC;
                    end
                end
            endcase
        end
    end

    assign op_push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            discard_reg   <= 1'b0;
            mask_low_reg  <= MASK_LOW_RESET;
            mask_high_reg <= MASK_HIGH_RESET;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                discard_reg <= discard_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MASK_LOW:  mask_low_reg  <= cfg_data;
                    CFG_MASK_HIGH: mask_high_reg <= cfg_data;
                    default:       mask_low_reg  <= mask_low_reg;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/pen_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pen_queue
// Short operation queue between front and back.
// ----------------------------------------------------------------------------
module pen_queue
    import pen_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire op_t  wr_op,
    input  wire logic rd_en,
    output op_t       rd_op,
    output logic      q_full,
    output logic      q_empty
);

    op_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;

    assign q_full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_op   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + QUEUE_CW'(1);
                2'b01:   count_reg <= count_reg - QUEUE_CW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/pen_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pen_back
// Expands queued operations into result words, one per cycle while the queue
// holds operations and pop keeps the output register free, into an output register.
// ----------------------------------------------------------------------------
module pen_back
    import pen_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_empty,
    input  wire op_t   q_op,
    output logic       q_pop,
    input  wire logic  pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       end_of_string,
    output logic       bad_escape
);

    typedef enum logic [1:0] {
        SEQ_PCT = 2'd0,
        SEQ_HI  = 2'd1,
        SEQ_LO  = 2'd2
    } seq_t;

    seq_t       seq_reg, seq_next;
    logic       valid_reg;
    logic [7:0] byte_reg, byte_next;
    logic       eos_reg, eos_next;
    logic       bad_reg, bad_next;
    logic       load;
    logic       done;

    assign load = !q_empty && (!valid_reg || pop);

    always_comb
    begin
        byte_next = q_op.data;
        eos_next  = q_op.last;
        bad_next  = 1'b0;
        seq_next  = seq_reg;
        done      = 1'b1;
        case (q_op.kind)
            OP_ERROR:
            begin
                byte_next = '0;
                eos_next  = 1'b1;
                bad_next  = 1'b1;
            end
            OP_ESC:
            begin
                case (seq_reg)
                    SEQ_PCT:
                    begin
                        byte_next = CHAR_PCT;
                        eos_next  = 1'b0;
                        seq_next  = SEQ_HI;
                        done      = 1'b0;
                    end
                    SEQ_HI:
                    begin
                        byte_next = hex_char(q_op.data[7:4] & NIBBLE_MASK);
                        eos_next  = 1'b0;
                        seq_next  = SEQ_LO;
                        done      = 1'b0;
                    end
                    default:
                    begin
                        byte_next = hex_char(q_op.data[3:0] & NIBBLE_MASK);
                        seq_next  = SEQ_PCT;
                    end
                endcase
            end
            default:
            begin
                seq_next = SEQ_PCT;
            end
        endcase
    end

    assign q_pop         = load && done;
    assign empty         = !valid_reg;
    assign out_byte      = byte_reg;
    assign end_of_string = eos_reg;
    assign bad_escape    = bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= SEQ_PCT;
            valid_reg <= 1'b0;
            byte_reg  <= '0;
            eos_reg   <= 1'b0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                seq_reg   <= seq_next;
                valid_reg <= 1'b1;
                byte_reg  <= byte_next;
                eos_reg   <= eos_next;
                bad_reg   <= bad_next;
            end
            else if (pop)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/percent_encoding_normalizer_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// percent_encoding_normalizer_core
// Percent-encoding normaliser for one URI component, byte per word.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------
//   input    | push / full            | in_byte, last_byte
//   result   | empty / pop            | out_byte, end_of_string, bad_escape
//   config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// The front classifies a word in the cycle it is taken and queues one
// operation; the back emits one result word per cycle while operations are
// queued and pop keeps its output register free, so an escaped byte yields
// three result words, a swallowed byte none and every other byte one.
// Sustained rate is set by the back's single output register. full rises
// when the four-entry queue fills. Reset is asynchronous; config is always ready.
// ----------------------------------------------------------------------------
module percent_encoding_normalizer_core
    import pen_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  in_byte,
    input  wire logic        last_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             end_of_string,
    output logic             bad_escape,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data
);

    op_t  front_op;
    op_t  head_op;
    logic front_push;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic accept;

    assign full      = q_full;
    assign cfg_ready = 1'b1;
    assign accept    = push && !q_full;

    pen_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .last_byte (last_byte),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op_push   (front_push),
        .op        (front_op)
    );

    pen_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_op   (front_op),
        .rd_en   (q_pop),
        .rd_op   (head_op),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    pen_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_op          (head_op),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .out_byte      (out_byte),
        .end_of_string (end_of_string),
        .bad_escape    (bad_escape)
    );

endmodule
`default_nettype wire
